// ----- hdl/itsp_pkg.sv -----
package itsp_pkg;

	// default width of the poll interval counter
	localparam int INTERVAL_BITS_DEF = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POINTER_BYTE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS    = 2'd3;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [15:0] INTERVAL_MS_RST    = 16'd1000;
	localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd73;
	localparam logic [7:0]  POINTER_BYTE_RST   = 8'd0;
	localparam logic [9:0]  PHASE_TICKS_RST    = 10'd4;

	// I2C R/W bit values appended to the address
	localparam logic I2C_WRITE = 1'b0;
	localparam logic I2C_READ  = 1'b1;

	// stream payload widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	// quarter codes inside one bit slot
	localparam logic [1:0] QTR_0 = 2'd0;
	localparam logic [1:0] QTR_1 = 2'd1;
	localparam logic [1:0] QTR_2 = 2'd2;
	localparam logic [1:0] QTR_3 = 2'd3;

	// bit slots per byte before the acknowledge slot
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_START1  = 4'd1,
		PH_WADDR   = 4'd2,
		PH_PTR     = 4'd3,
		PH_STOP1   = 4'd4,
		PH_START2  = 4'd5,
		PH_RADDR   = 4'd6,
		PH_READ_HI = 4'd7,
		PH_READ_LO = 4'd8,
		PH_STOP2   = 4'd9
	} phase_t;

	typedef struct packed {
		logic [15:0] interval_ms;
		logic [6:0]  device_address;
		logic [7:0]  pointer_byte;
		logic [9:0]  phase_ticks;
	} cfg_t;

	typedef struct packed {
		logic        scl_level;
		logic        sda_level;
		logic        sda_drive;
		logic [7:0]  temperature;
		logic        temp_new;
		logic        bus_busy;
	} res_t;

endpackage

// ----- hdl/itsp_cfg.sv -----
module itsp_cfg
	import itsp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register file, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_ms    <= INTERVAL_MS_RST;
			cfg_q.device_address <= DEVICE_ADDRESS_RST;
			cfg_q.pointer_byte   <= POINTER_BYTE_RST;
			cfg_q.phase_ticks    <= PHASE_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL_MS:    cfg_q.interval_ms    <= cfg_data;
				REG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data[6:0];
				REG_POINTER_BYTE:   cfg_q.pointer_byte   <= cfg_data[7:0];
				REG_PHASE_TICKS:    cfg_q.phase_ticks    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/itsp_seq.sv -----
module itsp_seq
	import itsp_pkg::*;
#(
	parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  logic phase_tick,
	input  logic ms_tick,
	input  logic sda_in,
	input  cfg_t cfg,
	output res_t res
);

	// sequencer state
	phase_t                   ph_q, n_ph;
	logic [1:0]               qtr_q, n_qtr;
	logic [9:0]               pcnt_q, n_pcnt;
	logic [3:0]               bcnt_q, n_bcnt;
	logic [7:0]               tx_q, n_tx;
	logic [15:0]              rx_q, n_rx;
	logic [INTERVAL_BITS-1:0] icnt_q, n_icnt;
	logic [7:0]               temp_q, n_temp;
	logic                     scl_q, sda_q, drv_q;
	logic                     n_scl, n_sda, n_drv;
	logic                     fresh;

	// timing helpers
	logic [9:0]               p_limit, p_next;
	logic [INTERVAL_BITS-1:0] i_target, i_next;
	logic                     byte_ph, read_ph, tx_ph;

	always_comb begin
		p_limit  = (cfg.phase_ticks != '0) ? cfg.phase_ticks : 10'd1;
		p_next   = pcnt_q + 10'd1;
		i_target = INTERVAL_BITS'(cfg.interval_ms);
		if (i_target == '0) begin
			i_target = INTERVAL_BITS'(1);
		end
		i_next   = icnt_q + INTERVAL_BITS'(1);
		tx_ph    = (ph_q == PH_WADDR) || (ph_q == PH_PTR) || (ph_q == PH_RADDR);
		read_ph  = (ph_q == PH_READ_HI) || (ph_q == PH_READ_LO);
		byte_ph  = tx_ph || read_ph;
	end

	// next state: one quarter step at most per beat
	always_comb begin
		n_ph   = ph_q;
		n_qtr  = qtr_q;
		n_pcnt = pcnt_q;
		n_bcnt = bcnt_q;
		n_tx   = tx_q;
		n_rx   = rx_q;
		n_icnt = icnt_q;
		n_temp = temp_q;
		fresh  = 1'b0;

		if (ph_q != PH_IDLE) begin
			if (phase_tick) begin
				if ((p_next >= p_limit) || (p_next == '0)) begin
					n_pcnt = '0;
					if (qtr_q != QTR_3) begin
						if ((qtr_q == QTR_2) && read_ph && (bcnt_q < BITS_PER_BYTE)) begin
							n_rx = {rx_q[14:0], sda_in};
						end
						n_qtr = qtr_q + 2'd1;
					end else if (byte_ph && (bcnt_q < BITS_PER_BYTE)) begin
						if (tx_ph) begin
							n_tx = {tx_q[6:0], 1'b0};
						end
						n_bcnt = bcnt_q + 4'd1;
						n_qtr  = QTR_0;
					end else begin
						// move on to the next phase
						n_qtr  = QTR_0;
						n_bcnt = '0;
						case (ph_q)
							PH_START1:  n_ph = PH_WADDR;
							PH_WADDR:   n_ph = PH_PTR;
							PH_PTR:     n_ph = PH_STOP1;
							PH_STOP1:   n_ph = PH_START2;
							PH_START2:  n_ph = PH_RADDR;
							PH_RADDR:   n_ph = PH_READ_HI;
							PH_READ_HI: n_ph = PH_READ_LO;
							PH_READ_LO: n_ph = PH_STOP2;
							PH_STOP2: begin
								n_ph   = PH_IDLE;
								n_temp = rx_q[15:8];
								fresh  = 1'b1;
							end
							default:    n_ph = PH_IDLE;
						endcase
						// byte loads at the start of a transmit phase
						case (n_ph)
							PH_WADDR: n_tx = {cfg.device_address, I2C_WRITE};
							PH_PTR:   n_tx = cfg.pointer_byte;
							PH_RADDR: n_tx = {cfg.device_address, I2C_READ};
							default: ;
						endcase
					end
				end else begin
					n_pcnt = p_next;
				end
			end
		end else if (ms_tick) begin
			if ((i_next >= i_target) || (i_next == '0)) begin
				n_icnt = '0;
				n_pcnt = '0;
				n_ph   = PH_START1;
				n_qtr  = QTR_0;
				n_bcnt = '0;
			end else begin
				n_icnt = i_next;
			end
		end
	end

	// line levels from the new step
	always_comb begin
		n_scl = scl_q;
		n_sda = sda_q;
		n_drv = drv_q;
		case (n_ph)
			PH_START1, PH_START2: begin
				n_drv = 1'b1;
				n_scl = (n_qtr == QTR_0) || (n_qtr == QTR_1);
				n_sda = (n_qtr == QTR_0);
			end
			PH_STOP1, PH_STOP2: begin
				if (n_qtr != QTR_0) begin
					n_drv = 1'b1;
					n_sda = (n_qtr == QTR_3);
				end
				n_scl = (n_qtr == QTR_2) || (n_qtr == QTR_3);
			end
			PH_WADDR, PH_PTR, PH_RADDR: begin
				n_scl = n_qtr[1];
				if (n_qtr != QTR_0) begin
					if (n_bcnt < BITS_PER_BYTE) begin
						n_sda = n_tx[7];
						n_drv = 1'b1;
					end else begin
						n_sda = 1'b1;
						n_drv = 1'b0;
					end
				end
			end
			PH_READ_HI, PH_READ_LO: begin
				n_scl = n_qtr[1];
				if (n_qtr != QTR_0) begin
					if (n_bcnt < BITS_PER_BYTE) begin
						n_sda = 1'b1;
						n_drv = 1'b0;
					end else begin
						n_sda = 1'b0;
						n_drv = 1'b1;
					end
				end
			end
			default: begin
				n_scl = 1'b1;
				n_sda = 1'b1;
				n_drv = 1'b1;
			end
		endcase
	end

	// state registers, advanced once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			qtr_q  <= QTR_0;
			pcnt_q <= '0;
			bcnt_q <= '0;
			tx_q   <= '0;
			rx_q   <= '0;
			icnt_q <= '0;
			temp_q <= '0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
			drv_q  <= 1'b1;
		end else if (fire) begin
			ph_q   <= n_ph;
			qtr_q  <= n_qtr;
			pcnt_q <= n_pcnt;
			bcnt_q <= n_bcnt;
			tx_q   <= n_tx;
			rx_q   <= n_rx;
			icnt_q <= n_icnt;
			temp_q <= n_temp;
			scl_q  <= n_scl;
			sda_q  <= n_sda;
			drv_q  <= n_drv;
		end
	end

	always_comb begin
		res.scl_level   = n_scl;
		res.sda_level   = n_sda;
		res.sda_drive   = n_drv;
		res.temperature = n_temp;
		res.temp_new    = fresh;
		res.bus_busy    = (n_ph != PH_IDLE);
	end

endmodule

// ----- hdl/i2c_temp_sensor_poller.sv -----
// Channel  Dir  Fields (lowest bit first)
// s_axis   in   tdata[7:0]: phase_tick, ms_tick, sda_in, zero fill
// m_axis   out  tdata[15:0]: scl_level, sda_level, sda_drive, temperature[7:0],
//               temp_new, bus_busy, zero fill
// cfg      in   cfg_we, cfg_index (0 interval_ms, 1 device_address,
//               2 pointer_byte, 3 phase_ticks), cfg_data
//
// One input beat per clock unless the output stalls; each beat gives one output beat
// through the input register, then the sequencer step into the output register.
// The I2C step logic advances at most one quarter bit per beat.
// Reset is asynchronous; the bus idles with SCL and SDA high, driven.
// A stalled output holds both stages; input ready drops only when both are full.
module i2c_temp_sensor_poller
	import itsp_pkg::*;
#(
	parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // phase_tick, ms_tick, sda_in
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // scl, sda, drive, temp[7:0], new, busy
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1, valid_s2;
	logic [2:0] in_s1;
	res_t       res_s2;
	logic       fire;

	itsp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1 moves into stage 2 when the output is free or taken
	assign fire     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || fire;

	itsp_seq #(
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.phase_tick (in_s1[0]),
		.ms_tick    (in_s1[1]),
		.sda_in     (in_s1[2]),
		.cfg        (cfg),
		.res        (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_s1 <= s_tdata[2:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, res_s2.bus_busy, res_s2.temp_new, res_s2.temperature,
		res_s2.sda_drive, res_s2.sda_level, res_s2.scl_level};

endmodule

// ----- tb/tb_i2c_temp_sensor_poller.sv -----
module tb_i2c_temp_sensor_poller
	import itsp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 250000;

	// Tracks the poller state beat by beat and holds the bus levels each input beat should give.
	class bus_poll_scoreboard;
		// register copies
		logic [15:0] interval_ms;
		logic [6:0]  dev_addr;
		logic [7:0]  ptr_byte;
		logic [9:0]  qtr_ticks;
		// sequencer copy
		phase_t      step_ph;
		logic [1:0]  qtr;
		logic [9:0]  tick_cnt;
		logic [3:0]  bit_cnt;
		logic [7:0]  tx_sh;
		logic [15:0] rx_sh;
		logic [INTERVAL_BITS_DEF-1:0] ms_cnt;
		logic [7:0]  temp_hold;
		logic        scl_q, sda_q, drv_q;
		res_t        pending_bus[$];
		int unsigned mismatches;
		int unsigned beats_seen;

		function new();
			interval_ms = INTERVAL_MS_RST;
			dev_addr    = DEVICE_ADDRESS_RST;
			ptr_byte    = POINTER_BYTE_RST;
			qtr_ticks   = PHASE_TICKS_RST;
			step_ph     = PH_IDLE;
			qtr         = QTR_0;
			tick_cnt    = '0;
			bit_cnt     = '0;
			tx_sh       = '0;
			rx_sh       = '0;
			ms_cnt      = '0;
			temp_hold   = '0;
			scl_q       = 1'b1;
			sda_q       = 1'b1;
			drv_q       = 1'b1;
			mismatches  = 0;
			beats_seen  = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_INTERVAL_MS:    interval_ms = val;
				REG_DEVICE_ADDRESS: dev_addr    = val[6:0];
				REG_POINTER_BYTE:   ptr_byte    = val[7:0];
				REG_PHASE_TICKS:    qtr_ticks   = val[9:0];
				default: ;
			endcase
		endfunction

		// new phase: address and pointer bytes are loaded here
		function void begin_phase(phase_t ph);
			step_ph = ph;
			qtr     = QTR_0;
			bit_cnt = '0;
			if (ph == PH_WADDR)
				tx_sh = {dev_addr, I2C_WRITE};
			else if (ph == PH_PTR)
				tx_sh = ptr_byte;
			else if (ph == PH_RADDR)
				tx_sh = {dev_addr, I2C_READ};
		endfunction

		// one quarter bit step; returns 1 when a reading gets stored
		function bit step_quarter(logic sda);
			bit rd_ph, wr_ph;
			rd_ph = (step_ph == PH_READ_HI || step_ph == PH_READ_LO);
			wr_ph = (step_ph == PH_WADDR || step_ph == PH_PTR || step_ph == PH_RADDR);
			if (qtr != QTR_3) begin
				if (qtr == QTR_2 && rd_ph && bit_cnt < BITS_PER_BYTE)
					rx_sh = {rx_sh[14:0], sda};
				qtr = qtr + 2'd1;
				return 1'b0;
			end
			if ((rd_ph || wr_ph) && bit_cnt < BITS_PER_BYTE) begin
				if (wr_ph)
					tx_sh = tx_sh << 1;
				bit_cnt = bit_cnt + 4'd1;
				qtr = QTR_0;
				return 1'b0;
			end
			if (step_ph == PH_STOP2) begin
				// top byte of the reading is the floored whole degrees
				temp_hold = rx_sh[15:8];
				begin_phase(PH_IDLE);
				return 1'b1;
			end
			begin_phase(phase_t'(step_ph + 1));
			return 1'b0;
		endfunction

		function void set_lines(logic scl, logic sda, logic drv);
			scl_q = scl;
			sda_q = sda;
			drv_q = drv;
		endfunction

		// line levels for the current quarter
		function void drive_lines();
			logic scl_hi;
			scl_hi = (qtr >= QTR_2);
			case (step_ph)
				PH_START1, PH_START2: begin
					if (qtr == QTR_0)      set_lines(1'b1, 1'b1, 1'b1);
					else if (qtr == QTR_1) set_lines(1'b1, 1'b0, 1'b1);
					else                   set_lines(1'b0, 1'b0, 1'b1);
				end
				PH_STOP1, PH_STOP2: begin
					if (qtr == QTR_0)      set_lines(1'b0, sda_q, drv_q);
					else if (qtr == QTR_1) set_lines(1'b0, 1'b0, 1'b1);
					else if (qtr == QTR_2) set_lines(1'b1, 1'b0, 1'b1);
					else                   set_lines(1'b1, 1'b1, 1'b1);
				end
				PH_WADDR, PH_PTR, PH_RADDR: begin
					if (qtr == QTR_0)                 set_lines(1'b0, sda_q, drv_q);
					else if (bit_cnt < BITS_PER_BYTE) set_lines(scl_hi, tx_sh[7], 1'b1);
					else                              set_lines(scl_hi, 1'b1, 1'b0);
				end
				PH_READ_HI, PH_READ_LO: begin
					// data bits released, master ACK driven low
					if (qtr == QTR_0)                 set_lines(1'b0, sda_q, drv_q);
					else if (bit_cnt < BITS_PER_BYTE) set_lines(scl_hi, 1'b1, 1'b0);
					else                              set_lines(scl_hi, 1'b0, 1'b1);
				end
				default: set_lines(1'b1, 1'b1, 1'b1);
			endcase
		endfunction

		// accepted input beat: advance state, queue the expected output beat
		function void take_sample(logic ptick, logic mtick, logic sda);
			logic [9:0] lim, nxt;
			logic [INTERVAL_BITS_DEF-1:0] tgt, ms_nxt;
			bit fresh;
			res_t exp_beat;
			fresh = 1'b0;
			if (step_ph != PH_IDLE) begin
				if (ptick) begin
					lim = (qtr_ticks == '0) ? 10'd1 : qtr_ticks;
					nxt = tick_cnt + 10'd1;
					if (nxt >= lim || nxt == '0) begin
						tick_cnt = '0;
						fresh = step_quarter(sda);
					end else begin
						tick_cnt = nxt;
					end
				end
			end else if (mtick) begin
				// zero interval behaves as one
				tgt = interval_ms;
				if (tgt == '0)
					tgt = INTERVAL_BITS_DEF'(1);
				ms_nxt = ms_cnt + 1'b1;
				if (ms_nxt >= tgt || ms_nxt == '0) begin
					ms_cnt = '0;
					tick_cnt = '0;
					begin_phase(PH_START1);
				end else begin
					ms_cnt = ms_nxt;
				end
			end
			drive_lines();
			exp_beat.scl_level   = scl_q;
			exp_beat.sda_level   = sda_q;
			exp_beat.sda_drive   = drv_q;
			exp_beat.temperature = temp_hold;
			exp_beat.temp_new    = fresh;
			exp_beat.bus_busy    = (step_ph != PH_IDLE);
			pending_bus.push_back(exp_beat);
		endfunction

		function void report_field(string fname, int unsigned expv, int unsigned actv);
			if (expv != actv) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on output beat %0d, %s: expected %0h, got %0h",
						beats_seen, fname, expv, actv);
			end
		endfunction

		// accepted output beat: compare against the oldest expectation
		function void match_output(logic [OUT_DATA_W-1:0] d);
			res_t exp_beat;
			if (pending_bus.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("output beat %0h with nothing expected", d);
				return;
			end
			exp_beat = pending_bus.pop_front();
			report_field("scl_level",   32'(exp_beat.scl_level),   32'(d[0]));
			report_field("sda_level",   32'(exp_beat.sda_level),   32'(d[1]));
			report_field("sda_drive",   32'(exp_beat.sda_drive),   32'(d[2]));
			report_field("temperature", 32'(exp_beat.temperature), 32'(d[10:3]));
			report_field("temp_new",    32'(exp_beat.temp_new),    32'(d[11]));
			report_field("bus_busy",    32'(exp_beat.bus_busy),    32'(d[12]));
			beats_seen++;
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bus_poll_scoreboard sb;
	bit          calm = 1'b0;       // no idling on either side
	bit          hold_req = 1'b0;   // ask the sink for one long hold-off
	bit          picked = 1'b0;
	int unsigned poll_no = 0;
	logic [15:0] reading = '0;      // sensor value played back on SDA
	int unsigned cycles = 0;

	i2c_temp_sensor_poller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// input beat: {sda_in, ms_tick, phase_tick}
	task automatic push_beat(input logic [2:0] bits);
		s_tdata  <= {{(IN_DATA_W-3){1'b0}}, bits};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.take_sample(bits[0], bits[1], bits[2]);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// mostly well-formed timing with the chosen reading on SDA, some noise
	function automatic logic [2:0] make_beat();
		logic pt, mt, sd;
		if (sb.step_ph == PH_IDLE && !picked) begin
			picked = 1'b1;
			case (poll_no)
				0: reading = {8'h80, 8'($urandom_range(0, 255))};
				1: reading = {8'h7F, 8'($urandom_range(0, 255))};
				2: reading = 16'hFFFF;
				3: reading = 16'h0000;
				default: reading = 16'($urandom);
			endcase
			poll_no++;
		end else if (sb.step_ph != PH_IDLE) begin
			picked = 1'b0;
		end
		if ($urandom_range(0, 9) == 0)
			return 3'($urandom_range(0, 7));
		pt = ($urandom_range(0, 15) != 0);
		mt = ($urandom_range(0, 3) != 0);
		sd = 1'($urandom_range(0, 1));
		if (sb.bit_cnt < BITS_PER_BYTE) begin
			if (sb.step_ph == PH_READ_HI)
				sd = reading[4'd15 - sb.bit_cnt];
			else if (sb.step_ph == PH_READ_LO)
				sd = reading[4'd7 - sb.bit_cnt];
		end
		return {sd, mt, pt};
	endfunction

	task automatic run_beats(input int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			push_beat(make_beat());
	endtask

	// stop sending and wait until every expected beat is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending_bus.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_reg(idx, val);
	endtask

	task automatic program_regs(input logic [15:0] iv, input logic [6:0] adr,
		input logic [7:0] ptr, input logic [9:0] qt);
		write_one(REG_INTERVAL_MS, iv);
		write_one(REG_DEVICE_ADDRESS, CFG_DATA_W'(adr));
		write_one(REG_POINTER_BYTE, CFG_DATA_W'(ptr));
		write_one(REG_PHASE_TICKS, CFG_DATA_W'(qt));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// output side: random stalls plus one long hold-off on request
	initial begin : sink
		int unsigned stall_left, hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.match_output(m_tdata);
			if (hold_req) begin
				hold_left = 300;
				hold_req  = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stim
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every strobe combination, idle counting only
		for (int i = 0; i < 24; i++)
			push_beat((i < 16) ? 3'(i) : ~3'(i));
		drain_results();

		// fastest polls, address and pointer extremes, long sink hold-off
		program_regs(16'd1, 7'd0, 8'hFF, 10'd1);
		hold_req = 1'b1;
		run_beats(420);
		drain_results();

		// slowest settings, possibly landing mid-poll
		program_regs(16'hFFFF, 7'h7F, 8'h00, 10'd1023);
		run_beats(40);
		drain_results();

		// zero interval and zero phase ticks both act as one
		program_regs(16'd0, 7'h2A, 8'h55, 10'd0);
		run_beats(420);
		drain_results();

		program_regs(16'd2, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 10'd2);
		run_beats(250);
		drain_results();

		// final stretch without idling
		calm = 1'b1;
		program_regs(16'd1, DEVICE_ADDRESS_RST, POINTER_BYTE_RST, 10'd1);
		run_beats(220);
		drain_results();

		if (sb.mismatches == 0 && sb.pending_bus.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/itsp_pkg.sv
hdl/itsp_cfg.sv
hdl/itsp_seq.sv
hdl/i2c_temp_sensor_poller.sv
tb/tb_i2c_temp_sensor_poller.sv
